// File: sv/gpuf_pkg.sv
// shared types and constants for the grid percolation union-find engine
// datapath opcodes, command and status structs; no dependencies
`default_nettype none

package gpuf_pkg;

	localparam int COORD_W = 6;
	localparam int GRID_W  = 7;
	localparam int COUNT_W = 13;

	localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_EMIT,
		DP_SWEEP_INIT,
		DP_SWEEP,
		DP_RD_SELF,
		DP_MARK_SELF,
		DP_NB_SEL,
		DP_FIND_START,
		DP_FIND_RD,
		DP_FIND_STEP,
		DP_LINK_SMALL,
		DP_LINK_BIG,
		DP_SET_PERC
	} dp_op_t;

	// result kinds for DP_EMIT
	localparam logic [1:0] EM_NORMAL = 2'd0;
	localparam logic [1:0] EM_WAS    = 2'd1;
	localparam logic [1:0] EM_BAD    = 2'd2;
	localparam logic [1:0] EM_CLEAR  = 2'd3;

	// neighbor selects for DP_NB_SEL
	localparam logic [1:0] NB_LEFT  = 2'd0;
	localparam logic [1:0] NB_RIGHT = 2'd1;
	localparam logic [1:0] NB_UP    = 2'd2;
	localparam logic [1:0] NB_DOWN  = 2'd3;

	// find start points; bit 0 also picks the root slot (a or b)
	localparam logic [1:0] FS_SELF   = 2'd0;
	localparam logic [1:0] FS_NB     = 2'd1;
	localparam logic [1:0] FS_TOP    = 2'd2;
	localparam logic [1:0] FS_BOTTOM = 2'd3;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic bad;
		logic open_rd;
		logic nb_exists;
		logic nb_virtual;
		logic is_root;
		logic same_root;
		logic sweep_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: sv/gpuf_ctrl.sv
// controller state machine of the percolation engine
// sequences the datapath through dp_cmd_t commands; uses gpuf_pkg
`default_nettype none

module gpuf_ctrl import gpuf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire logic     cfg_we,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd_o,
	output logic          busy
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT_CLR,
		ST_SWEEP_INIT,
		ST_SWEEP,
		ST_EMIT_END,
		ST_RD_SELF,
		ST_SELF_WAIT,
		ST_MARK,
		ST_NB,
		ST_NB_WAIT,
		ST_FIND_START,
		ST_FIND_RD,
		ST_FIND_STEP,
		ST_LINK_CHK,
		ST_LINK1,
		ST_LINK2,
		ST_PERC
	} state_t;

	state_t     state_q;
	dp_cmd_t    cmd_q;
	logic       busy_q;
	logic [1:0] k_q;
	logic [1:0] phase_q;

	// move on to the next neighbor, or to the top/bottom query after the last
	state_t     adv_state;
	dp_cmd_t    adv_cmd;
	logic [1:0] adv_phase;

	always_comb begin
		if (k_q == NB_DOWN) begin
			adv_state = ST_FIND_START;
			adv_cmd   = '{op: DP_FIND_START, sel: FS_TOP};
			adv_phase = FS_TOP;
		end else begin
			adv_state = ST_NB;
			adv_cmd   = '{op: DP_NB_SEL, sel: k_q + 2'd1};
			adv_phase = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP_INIT;
			cmd_q   <= '{op: DP_SWEEP_INIT, sel: 2'd0};
			busy_q  <= 1'b1;
			k_q     <= 2'd0;
			phase_q <= FS_SELF;
		end else if (cfg_we) begin
			state_q <= ST_SWEEP_INIT;
			cmd_q   <= '{op: DP_SWEEP_INIT, sel: 2'd0};
			busy_q  <= 1'b1;
		end else begin
			cmd_q <= '{op: DP_NOP, sel: 2'd0};
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
						busy_q  <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (stat.is_clear) begin
						state_q <= ST_EMIT_CLR;
						cmd_q   <= '{op: DP_EMIT, sel: EM_CLEAR};
					end else if (stat.bad) begin
						state_q <= ST_EMIT_END;
						cmd_q   <= '{op: DP_EMIT, sel: EM_BAD};
					end else begin
						state_q <= ST_RD_SELF;
						cmd_q   <= '{op: DP_RD_SELF, sel: 2'd0};
					end
				end
				ST_EMIT_CLR: begin
					state_q <= ST_SWEEP_INIT;
					cmd_q   <= '{op: DP_SWEEP_INIT, sel: 2'd0};
				end
				ST_SWEEP_INIT: begin
					state_q <= ST_SWEEP;
					cmd_q   <= '{op: DP_SWEEP, sel: 2'd0};
				end
				ST_SWEEP: begin
					if (stat.sweep_done) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else begin
						cmd_q <= '{op: DP_SWEEP, sel: 2'd0};
					end
				end
				ST_EMIT_END: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				ST_RD_SELF: begin
					state_q <= ST_SELF_WAIT;
				end
				ST_SELF_WAIT: begin
					if (stat.open_rd) begin
						state_q <= ST_EMIT_END;
						cmd_q   <= '{op: DP_EMIT, sel: EM_WAS};
					end else begin
						state_q <= ST_MARK;
						cmd_q   <= '{op: DP_MARK_SELF, sel: 2'd0};
					end
				end
				ST_MARK: begin
					state_q <= ST_NB;
					cmd_q   <= '{op: DP_NB_SEL, sel: NB_LEFT};
					k_q     <= NB_LEFT;
				end
				ST_NB: begin
					if (!stat.nb_exists) begin
						state_q <= adv_state;
						cmd_q   <= adv_cmd;
						phase_q <= adv_phase;
						k_q     <= k_q + 2'd1;
					end else if (stat.nb_virtual) begin
						state_q <= ST_FIND_START;
						cmd_q   <= '{op: DP_FIND_START, sel: FS_SELF};
						phase_q <= FS_SELF;
					end else begin
						state_q <= ST_NB_WAIT;
					end
				end
				ST_NB_WAIT: begin
					if (stat.open_rd) begin
						state_q <= ST_FIND_START;
						cmd_q   <= '{op: DP_FIND_START, sel: FS_SELF};
						phase_q <= FS_SELF;
					end else begin
						state_q <= adv_state;
						cmd_q   <= adv_cmd;
						phase_q <= adv_phase;
						k_q     <= k_q + 2'd1;
					end
				end
				ST_FIND_START: begin
					state_q <= ST_FIND_RD;
					cmd_q   <= '{op: DP_FIND_RD, sel: phase_q};
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_STEP;
					cmd_q   <= '{op: DP_FIND_STEP, sel: phase_q};
				end
				ST_FIND_STEP: begin
					if (!stat.is_root) begin
						state_q <= ST_FIND_RD;
						cmd_q   <= '{op: DP_FIND_RD, sel: phase_q};
					end else begin
						case (phase_q)
							FS_SELF: begin
								state_q <= ST_FIND_START;
								cmd_q   <= '{op: DP_FIND_START, sel: FS_NB};
								phase_q <= FS_NB;
							end
							FS_NB: begin
								state_q <= ST_LINK_CHK;
							end
							FS_TOP: begin
								state_q <= ST_FIND_START;
								cmd_q   <= '{op: DP_FIND_START, sel: FS_BOTTOM};
								phase_q <= FS_BOTTOM;
							end
							default: begin
								state_q <= ST_PERC;
								cmd_q   <= '{op: DP_SET_PERC, sel: 2'd0};
							end
						endcase
					end
				end
				ST_LINK_CHK: begin
					if (stat.same_root) begin
						state_q <= adv_state;
						cmd_q   <= adv_cmd;
						phase_q <= adv_phase;
						k_q     <= k_q + 2'd1;
					end else begin
						state_q <= ST_LINK1;
						cmd_q   <= '{op: DP_LINK_SMALL, sel: 2'd0};
					end
				end
				ST_LINK1: begin
					state_q <= ST_LINK2;
					cmd_q   <= '{op: DP_LINK_BIG, sel: 2'd0};
				end
				ST_LINK2: begin
					state_q <= adv_state;
					cmd_q   <= adv_cmd;
					phase_q <= adv_phase;
					k_q     <= k_q + 2'd1;
				end
				ST_PERC: begin
					state_q <= ST_EMIT_END;
					cmd_q   <= '{op: DP_EMIT, sel: EM_NORMAL};
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd_o = cmd_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

// File: sv/gpuf_dp.sv
// datapath of the percolation engine: open map and union-find memories,
// root registers, counters and result registers; uses gpuf_pkg
`default_nettype none

module gpuf_dp import gpuf_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               in_cmd,
	input  wire logic [COORD_W-1:0] in_row,
	input  wire logic [COORD_W-1:0] in_col,
	input  wire logic               cfg_we,
	input  wire logic [GRID_W-1:0]  cfg_data,
	input  wire dp_cmd_t            cmd_i,
	output dp_stat_t                stat,
	output logic                    done,
	output logic                    system_percolates,
	output logic [COUNT_W-1:0]      open_count,
	output logic                    was_open,
	output logic                    bad_site
);

	localparam int SITE_COUNT = MAX_SIDE * MAX_SIDE;
	localparam int NODE_COUNT = SITE_COUNT + 2;
	localparam int SITE_W     = $clog2(SITE_COUNT);
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int SIZE_W     = $clog2(NODE_COUNT + 1);
	localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
	localparam int CW         = ((SIDE_W > GRID_W) ? SIDE_W : GRID_W) + 1;

	localparam logic [NODE_W-1:0] TOP_NODE    = '0;
	localparam logic [NODE_W-1:0] BOTTOM_NODE = NODE_W'(NODE_COUNT - 1);

	logic                  open_mem [SITE_COUNT];
	logic [NODE_W-1:0]     par_mem  [NODE_COUNT];
	logic [SIZE_W-1:0]     size_mem [NODE_COUNT];

	logic [GRID_W-1:0]     grid_q;
	logic [CW-1:0]         n_q;
	logic [COORD_W-1:0]    r_q, c_q;
	logic                  clr_q;
	logic [SITE_W-1:0]     idx_q;
	logic                  open_rd_q;
	logic [NODE_W-1:0]     par_rd_q;
	logic [SIZE_W-1:0]     size_rd_q;
	logic [NODE_W-1:0]     walk_q, nb_node_q, root_a_q, root_b_q;
	logic [SIZE_W-1:0]     size_a_q, size_b_q;
	logic [NODE_W-1:0]     sweep_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic                  perc_q;
	logic                  done_q, res_perc_q, res_was_q, res_bad_q;
	logic [COUNT_W-1:0]    res_cnt_q;

	// effective side: zero acts as one, clipped to the array size
	logic [CW-1:0] g_ext, eff_side;
	always_comb begin
		g_ext = CW'(grid_q);
		if (g_ext == '0) eff_side = CW'(1);
		else if (g_ext > CW'(MAX_SIDE)) eff_side = CW'(MAX_SIDE);
		else eff_side = g_ext;
	end

	logic [NODE_W-1:0] me_node;
	assign me_node = NODE_W'(idx_q) + NODE_W'(1);

	// neighbor picked by cmd_i.sel
	logic              nb_exists, nb_virtual;
	logic [SITE_W-1:0] nb_idx;
	logic [NODE_W-1:0] nb_node;
	always_comb begin
		nb_exists  = 1'b0;
		nb_virtual = 1'b0;
		nb_idx     = idx_q;
		nb_node    = me_node;
		case (cmd_i.sel)
			NB_LEFT: begin
				nb_exists = (c_q != '0);
				nb_idx    = idx_q - SITE_W'(1);
				nb_node   = me_node - NODE_W'(1);
			end
			NB_RIGHT: begin
				nb_exists = (CW'(c_q) + CW'(1)) < n_q;
				nb_idx    = idx_q + SITE_W'(1);
				nb_node   = me_node + NODE_W'(1);
			end
			NB_UP: begin
				nb_exists = 1'b1;
				if (r_q != '0) begin
					nb_idx  = idx_q - SITE_W'(MAX_SIDE);
					nb_node = me_node - NODE_W'(MAX_SIDE);
				end else begin
					nb_virtual = 1'b1;
					nb_node    = TOP_NODE;
				end
			end
			default: begin
				nb_exists = 1'b1;
				if ((CW'(r_q) + CW'(1)) < n_q) begin
					nb_idx  = idx_q + SITE_W'(MAX_SIDE);
					nb_node = me_node + NODE_W'(MAX_SIDE);
				end else begin
					nb_virtual = 1'b1;
					nb_node    = BOTTOM_NODE;
				end
			end
		endcase
	end

	// open map port
	logic              open_we, open_wd, open_re;
	logic [SITE_W-1:0] open_wa, open_ra;
	always_comb begin
		open_we = 1'b0;
		open_wd = 1'b0;
		open_wa = idx_q;
		if (cmd_i.op == DP_SWEEP && sweep_q < NODE_W'(SITE_COUNT)) begin
			open_we = 1'b1;
			open_wa = sweep_q[SITE_W-1:0];
		end else if (cmd_i.op == DP_MARK_SELF) begin
			open_we = 1'b1;
			open_wd = 1'b1;
		end
		open_re = (cmd_i.op == DP_RD_SELF) || (cmd_i.op == DP_NB_SEL);
		open_ra = (cmd_i.op == DP_RD_SELF) ? idx_q : nb_idx;
	end

	always_ff @(posedge clk) begin
		if (open_we) open_mem[open_wa] <= open_wd;
		if (open_re) open_rd_q <= open_mem[open_ra];
	end

	// forest port: union by tree size, smaller root goes under larger
	logic              a_small;
	logic              uf_we;
	logic [NODE_W-1:0] uf_wa, uf_wpar;
	logic [SIZE_W-1:0] uf_wsize;
	always_comb begin
		a_small  = size_a_q < size_b_q;
		uf_we    = 1'b0;
		uf_wa    = sweep_q;
		uf_wpar  = sweep_q;
		uf_wsize = SIZE_W'(1);
		case (cmd_i.op)
			DP_SWEEP: begin
				uf_we = 1'b1;
			end
			DP_LINK_SMALL: begin
				uf_we    = 1'b1;
				uf_wa    = a_small ? root_a_q : root_b_q;
				uf_wpar  = a_small ? root_b_q : root_a_q;
				uf_wsize = a_small ? size_a_q : size_b_q;
			end
			DP_LINK_BIG: begin
				uf_we    = 1'b1;
				uf_wa    = a_small ? root_b_q : root_a_q;
				uf_wpar  = a_small ? root_b_q : root_a_q;
				uf_wsize = size_a_q + size_b_q;
			end
			default: begin
				uf_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (uf_we) begin
			par_mem[uf_wa]  <= uf_wpar;
			size_mem[uf_wa] <= uf_wsize;
		end
		if (cmd_i.op == DP_FIND_RD) begin
			par_rd_q  <= par_mem[walk_q];
			size_rd_q <= size_mem[walk_q];
		end
	end

	logic is_root;
	assign is_root = (par_rd_q == walk_q);

	// captured transaction fields and find registers
	always_ff @(posedge clk) begin
		if (accept) begin
			clr_q <= in_cmd;
			r_q   <= in_row;
			c_q   <= in_col;
			n_q   <= eff_side;
			idx_q <= SITE_W'(in_row) * SITE_W'(MAX_SIDE) + SITE_W'(in_col);
		end
		if (cmd_i.op == DP_NB_SEL) nb_node_q <= nb_node;
		if (cmd_i.op == DP_FIND_START) begin
			case (cmd_i.sel)
				FS_SELF: walk_q <= me_node;
				FS_NB:   walk_q <= nb_node_q;
				FS_TOP:  walk_q <= TOP_NODE;
				default: walk_q <= BOTTOM_NODE;
			endcase
		end else if (cmd_i.op == DP_FIND_STEP) begin
			if (!is_root) begin
				walk_q <= par_rd_q;
			end else if (cmd_i.sel[0]) begin
				root_b_q <= walk_q;
				size_b_q <= size_rd_q;
			end else begin
				root_a_q <= walk_q;
				size_a_q <= size_rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= GRID_RESET;
			sweep_q <= '0;
			cnt_q   <= '0;
			perc_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) grid_q <= cfg_data;
			done_q <= (cmd_i.op == DP_EMIT);
			case (cmd_i.op)
				DP_SWEEP_INIT: begin
					sweep_q <= '0;
					cnt_q   <= '0;
					perc_q  <= 1'b0;
				end
				DP_SWEEP:     sweep_q <= sweep_q + NODE_W'(1);
				DP_MARK_SELF: cnt_q   <= cnt_q + COUNT_W'(1);
				DP_SET_PERC:  perc_q  <= (root_a_q == root_b_q);
				default: begin
					perc_q <= perc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.op == DP_EMIT) begin
			if (cmd_i.sel == EM_CLEAR) begin
				res_perc_q <= 1'b0;
				res_cnt_q  <= '0;
			end else begin
				res_perc_q <= perc_q;
				res_cnt_q  <= cnt_q;
			end
			res_was_q <= (cmd_i.sel == EM_WAS);
			res_bad_q <= (cmd_i.sel == EM_BAD);
		end
	end

	always_comb begin
		stat.is_clear   = clr_q;
		stat.bad        = (CW'(r_q) >= n_q) || (CW'(c_q) >= n_q);
		stat.open_rd    = open_rd_q;
		stat.nb_exists  = nb_exists;
		stat.nb_virtual = nb_virtual;
		stat.is_root    = is_root;
		stat.same_root  = (root_a_q == root_b_q);
		stat.sweep_done = (sweep_q == NODE_W'(NODE_COUNT - 1));
	end

	assign done              = done_q;
	assign system_percolates = res_perc_q;
	assign open_count        = res_cnt_q;
	assign was_open          = res_was_q;
	assign bad_site          = res_bad_q;

endmodule

`default_nettype wire

// File: sv/grid_percolation_union_find.sv
// top level of the grid percolation union-find engine
// joins gpuf_ctrl and gpuf_dp; uses gpuf_pkg
`default_nettype none

// A transaction is taken when start is high and busy is low; its result shows
// on the result ports for one cycle with done high and cannot be held off.
// A clear gives its result, then the block sweeps the open map and forest, one
// node per cycle, with busy high. The same sweep runs after reset and after
// every grid_size write. An out-of-range site is answered straight after
// decode and an already-open site after one read of the open map. Opening a
// new site marks it and checks each neighbor, and for each of up to four joins
// and the final top/bottom query walks two trees to their roots, a start step
// then a read and a step per tree level (single-ported forest memory); each
// join has a root compare, and two link writes when the roots differ. With
// union by size trees stay shallow.
module grid_percolation_union_find import gpuf_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cmd,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic               cfg_we,
	input  wire logic [GRID_W-1:0]  cfg_data,
	output logic                    done,
	output logic                    system_percolates,
	output logic [COUNT_W-1:0]      open_count,
	output logic                    was_open,
	output logic                    bad_site
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     accept;

	assign accept = start && !busy;

	gpuf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cfg_we (cfg_we),
		.stat   (dp_stat),
		.cmd_o  (dp_cmd),
		.busy   (busy)
	);

	gpuf_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.in_cmd            (cmd),
		.in_row            (row),
		.in_col            (col),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.cmd_i             (dp_cmd),
		.stat              (dp_stat),
		.done              (done),
		.system_percolates (system_percolates),
		.open_count        (open_count),
		.was_open          (was_open),
		.bad_site          (bad_site)
	);

	// one result per transaction, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted transaction");

	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("grid size write did not start the clearing sweep");

	a_bad_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_site) |-> !was_open)
		else $error("out-of-range site reported as already open");

endmodule

`default_nettype wire

// File: bench/percolation_bench_pkg.sv
// command codes and result record shared by the percolation bench files
// depends on gpuf_pkg for field widths
`timescale 1ns / 1ps

package percolation_bench_pkg;
	import gpuf_pkg::*;

	localparam logic CMD_OPEN  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic               percolates;
		logic [COUNT_W-1:0] count;
		logic               was;
		logic               bad;
	} site_result_t;
endpackage

// File: bench/percolation_checker.sv
// watches the command, config and result ports of the percolation engine,
// keeps its own union-find copy of the grid and compares every result
// depends on gpuf_pkg and percolation_bench_pkg
`timescale 1ns / 1ps

module percolation_checker import gpuf_pkg::*, percolation_bench_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic               cmd,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic               cfg_we,
	input  wire logic [GRID_W-1:0]  cfg_data,
	input  wire logic               done,
	input  wire logic               system_percolates,
	input  wire logic [COUNT_W-1:0] open_count,
	input  wire logic               was_open,
	input  wire logic               bad_site,
	output int                      errors,
	output int                      outstanding
);
	localparam int SIDE   = 64;
	localparam int SITES  = SIDE * SIDE;
	localparam int NODES  = SITES + 2;
	localparam int TOP    = 0;
	localparam int BOTTOM = SITES + 1;

	logic [GRID_W-1:0]  side_reg;
	logic               site_is_open [SITES];
	int                 link [NODES];
	int                 weight [NODES];
	logic [COUNT_W-1:0] opened;
	site_result_t       pending_results [$];

	assign outstanding = pending_results.size();

	task automatic wipe_grid();
		for (int k = 0; k < NODES; k++) begin
			link[k] = k;
			weight[k] = 1;
		end
		for (int k = 0; k < SITES; k++)
			site_is_open[k] = 1'b0;
		opened = '0;
	endtask

	// path halving; the forest walk in the engine does no path compression
	function automatic int root_of(int n);
		int gp;
		while (link[n] != n) begin
			gp = link[link[n]];
			link[n] = gp;
			n = gp;
		end
		return n;
	endfunction

	task automatic merge(int a, int b);
		int ra, rb;
		ra = root_of(a);
		rb = root_of(b);
		if (ra != rb) begin
			if (weight[ra] < weight[rb]) begin
				link[ra] = rb;
				weight[rb] += weight[ra];
			end else begin
				link[rb] = ra;
				weight[ra] += weight[rb];
			end
		end
	endtask

	task automatic predict_site(input logic c, input int r, input int q,
			output site_result_t res);
		int n, me;
		n = (side_reg == 0) ? 1 : (side_reg > SIDE) ? SIDE : int'(side_reg);
		res = '0;
		if (c == CMD_CLEAR) begin
			wipe_grid();
		end else if (r >= n || q >= n) begin
			res.bad = 1'b1;
		end else if (site_is_open[r*SIDE+q]) begin
			res.was = 1'b1;
		end else begin
			me = r*SIDE + q + 1;
			site_is_open[r*SIDE+q] = 1'b1;
			opened++;
			if (q >= 1 && site_is_open[r*SIDE+q-1]) merge(me, me-1);
			if (q+1 < n && site_is_open[r*SIDE+q+1]) merge(me, me+1);
			if (r >= 1) begin
				if (site_is_open[(r-1)*SIDE+q]) merge(me, me-SIDE);
			end else begin
				merge(me, TOP);
			end
			if (r+1 < n) begin
				if (site_is_open[(r+1)*SIDE+q]) merge(me, me+SIDE);
			end else begin
				merge(me, BOTTOM);
			end
		end
		if (c != CMD_CLEAR) begin
			res.percolates = (root_of(TOP) == root_of(BOTTOM));
			res.count = opened;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		site_result_t want, got;
		if (!arst_n) begin
			side_reg <= GRID_RESET;
			wipe_grid();
			pending_results.delete();
			errors <= 0;
		end else begin
			if (done) begin
				got = '{system_percolates, open_count, was_open, bad_site};
				if (pending_results.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (cfg_we) begin
				side_reg <= cfg_data;
				wipe_grid();
			end
			if (start && !busy) begin
				predict_site(cmd, int'(row), int'(col), want);
				pending_results.push_back(want);
			end
		end
	end
endmodule

// File: bench/grid_percolation_union_find_test.sv
// stimulus and verdict for the grid percolation union-find engine
// depends on grid_percolation_union_find, percolation_checker and the packages
`timescale 1ns / 1ps

module grid_percolation_union_find_test;
	import gpuf_pkg::*;
	import percolation_bench_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               cmd = CMD_OPEN;
	logic [COORD_W-1:0] row = '0;
	logic [COORD_W-1:0] col = '0;
	logic               cfg_we = 1'b0;
	logic [GRID_W-1:0]  cfg_data = '0;
	logic               busy, done, system_percolates, was_open, bad_site;
	logic [COUNT_W-1:0] open_count;
	int                 errors, outstanding;
	int                 cycles = 0;
	int                 idle_pct = 0;
	int                 side_now = 64;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_percolation_union_find uut (
		.clk, .arst_n, .start, .busy, .cmd, .row, .col, .cfg_we, .cfg_data,
		.done, .system_percolates, .open_count, .was_open, .bad_site
	);

	percolation_checker u_checker (
		.clk, .arst_n, .start, .busy, .cmd, .row, .col, .cfg_we, .cfg_data,
		.done, .system_percolates, .open_count, .was_open, .bad_site,
		.errors, .outstanding
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("grid_percolation_union_find_test: errors");
			$finish;
		end
	end

	task automatic send(input logic c, input int r, input int q);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		row <= r[COORD_W-1:0];
		col <= q[COORD_W-1:0];
		do @(posedge clk); while (busy);
	endtask

	task automatic set_side(input int v);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[GRID_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		side_now = (v == 0) ? 1 : (v > 64) ? 64 : v;
	endtask

	task automatic random_items(input int count);
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(999);
			if (pick < 12)
				send(CMD_CLEAR, $urandom_range(63), $urandom_range(63));
			else if (pick < 200)
				send(CMD_OPEN, $urandom_range(63), $urandom_range(63));
			else
				send(CMD_OPEN, $urandom_range(side_now-1), $urandom_range(side_now-1));
		end
	endtask

	initial begin
		int sizes [6] = '{5, 64, 2, 9, 127, 16};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: clamped sizes, corners, reopen, out of range, clear
		set_side(0);
		send(CMD_OPEN, 0, 0);
		send(CMD_OPEN, 0, 0);
		send(CMD_OPEN, 63, 63);
		send(CMD_OPEN, 0, 1);
		send(CMD_CLEAR, 63, 63);
		set_side(127);
		send(CMD_OPEN, 63, 63);
		send(CMD_OPEN, 0, 0);
		send(CMD_OPEN, 0, 63);
		send(CMD_OPEN, 63, 0);
		send(CMD_OPEN, 63, 0);
		send(CMD_CLEAR, 0, 0);
		set_side(2);
		send(CMD_OPEN, 0, 1);
		send(CMD_OPEN, 1, 0);
		send(CMD_OPEN, 1, 1);
		send(CMD_OPEN, 2, 0);
		send(CMD_OPEN, 0, 0);
		send(CMD_CLEAR, 1, 1);
		send(CMD_OPEN, 1, 1);
		set_side(1);
		send(CMD_OPEN, 0, 0);

		for (int p = 0; p < 6; p++) begin
			idle_pct = (p < 2) ? 9 : (p < 4) ? 86 : 0;
			set_side((p == 5) ? $urandom_range(127) : sizes[p]);
			random_items(270);
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("grid_percolation_union_find_test: clean");
		end else begin
			$display("grid_percolation_union_find_test: errors");
		end
		$finish;
	end
endmodule
